// ----- design/ile_pkg.sv -----
package ile_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int DATA_WIDTH_DEF  = 32;

    // Fixed field widths of the stream words
    localparam int CMD_W   = 4;
    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int AMT_W   = 16;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 40;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 4'd0,
        CMD_POP    = 4'd1,
        CMD_GET    = 4'd2,
        CMD_SET    = 4'd3,
        CMD_INSERT = 4'd4,
        CMD_REMOVE = 4'd5,
        CMD_ROTL   = 4'd6,
        CMD_ROTR   = 4'd7,
        CMD_CLEAR  = 4'd8,
        CMD_NOP    = 4'd9
    } ile_cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } ile_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_ROT
    } ile_state_t;

    typedef enum logic [2:0] {
        SH_NONE,
        SH_WRITE,
        SH_INSERT,
        SH_REMOVE,
        SH_ROTATE
    } ile_shift_t;

    // One decoded command as it travels through the queue
    typedef struct packed {
        ile_cmd_t           cmd;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] value;
        logic [AMT_W-1:0]   amt;
    } ile_item_t;

endpackage

// ----- design/ile_front.sv -----
module ile_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // command[3:0], position[8:4], value_in[40:9], rotate_amount[56:41], zero[63:57]
    input  logic [ile_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            push_valid,
    input  logic                            push_ready,
    output ile_pkg::ile_item_t              push_item
);

    logic                 hold_valid_reg;
    logic                 hold_valid_next;
    ile_pkg::ile_item_t   hold_item_reg;
    ile_pkg::ile_item_t   dec_item;
    logic                 take;

    // Classify the raw command code; unused codes become no-ops
    always_comb
    begin
        dec_item.pos   = s_tdata[8:4];
        dec_item.value = s_tdata[40:9];
        dec_item.amt   = s_tdata[56:41];
        case (s_tdata[3:0])
            ile_pkg::CMD_PUSH:   dec_item.cmd = ile_pkg::CMD_PUSH;
            ile_pkg::CMD_POP:    dec_item.cmd = ile_pkg::CMD_POP;
            ile_pkg::CMD_GET:    dec_item.cmd = ile_pkg::CMD_GET;
            ile_pkg::CMD_SET:    dec_item.cmd = ile_pkg::CMD_SET;
            ile_pkg::CMD_INSERT: dec_item.cmd = ile_pkg::CMD_INSERT;
            ile_pkg::CMD_REMOVE: dec_item.cmd = ile_pkg::CMD_REMOVE;
            ile_pkg::CMD_ROTL:   dec_item.cmd = ile_pkg::CMD_ROTL;
            ile_pkg::CMD_ROTR:   dec_item.cmd = ile_pkg::CMD_ROTR;
            ile_pkg::CMD_CLEAR:  dec_item.cmd = ile_pkg::CMD_CLEAR;
            default:             dec_item.cmd = ile_pkg::CMD_NOP;
        endcase
    end

    // Accept a word whenever the holding stage is empty or drains this cycle
    assign s_tready   = !hold_valid_reg || push_ready;
    assign take       = s_tvalid && s_tready;
    assign push_valid = hold_valid_reg;
    assign push_item  = hold_item_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Hold the decoded word
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_item_reg <= dec_item;
        end
    end

endmodule

// ----- design/ile_queue.sv -----
module ile_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  ile_pkg::ile_item_t   push_item,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output ile_pkg::ile_item_t   pop_item
);

    localparam int DEPTH  = ile_pkg::QUEUE_DEPTH;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    ile_pkg::ile_item_t  slots_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (fill_reg != FILL_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_item   = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- design/ile_divider.sv -----
module ile_divider
#(
    parameter int CNT_W = 5
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ile_pkg::AMT_W-1:0]  dividend,
    input  logic [CNT_W-1:0]           divisor,
    output logic                       done,
    output logic [CNT_W-1:0]           remainder
);

    localparam int STEP_W = $clog2(ile_pkg::AMT_W + 1);

    logic                       busy_reg;
    logic                       busy_next;
    logic                       done_reg;
    logic                       done_next;
    logic [STEP_W-1:0]          step_reg;
    logic [STEP_W-1:0]          step_next;
    logic [ile_pkg::AMT_W-1:0]  quo_reg;
    logic [ile_pkg::AMT_W-1:0]  quo_next;
    logic [CNT_W-1:0]           rem_reg;
    logic [CNT_W-1:0]           rem_next;
    logic [CNT_W-1:0]           div_reg;
    logic [CNT_W-1:0]           div_next;
    logic [CNT_W:0]             trial;

    assign done      = done_reg;
    assign remainder = rem_reg;

    // Restoring division, one dividend bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        trial     = {rem_reg, quo_reg[ile_pkg::AMT_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(ile_pkg::AMT_W);
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[ile_pkg::AMT_W-2:0], 1'b0};
            step_next = step_reg - STEP_W'(1);
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = CNT_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
            end
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

endmodule

// ----- design/ile_back.sv -----
module ile_back
#(
    parameter int MAX_ENTRIES = ile_pkg::MAX_ENTRIES_DEF,
    parameter int DATA_WIDTH  = ile_pkg::DATA_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  ile_pkg::ile_item_t              q_item,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[1:0], value_out[33:2], entry_count[38:34], zero[39]
    output logic [ile_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int IW   = $clog2(MAX_ENTRIES);
    localparam int CMPW = (CW > ile_pkg::POS_W) ? CW : ile_pkg::POS_W;

    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);

    // List storage and control
    logic [DATA_WIDTH-1:0]  entries_reg  [MAX_ENTRIES];
    logic [DATA_WIDTH-1:0]  entries_next [MAX_ENTRIES];
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    ile_pkg::ile_state_t    state_reg;
    ile_pkg::ile_state_t    state_next;
    logic                   rot_left_reg;
    logic                   rot_left_next;
    logic [CW-1:0]          steps_reg;
    logic [CW-1:0]          steps_next;

    // Result register
    logic                   out_valid_reg;
    logic                   out_valid_next;
    ile_pkg::ile_status_t   out_status_reg;
    ile_pkg::ile_status_t   out_status_next;
    logic [DATA_WIDTH-1:0]  out_value_reg;
    logic [DATA_WIDTH-1:0]  out_value_next;
    logic [CW-1:0]          out_count_reg;
    logic [CW-1:0]          out_count_next;

    // Working signals
    ile_pkg::ile_shift_t    shift_op;
    logic [CW-1:0]          wr_idx;
    logic [DATA_WIDTH-1:0]  wr_val;
    logic [63:0]            vin_w;
    logic [CMPW-1:0]        pos_ext;
    logic [CMPW-1:0]        cnt_ext;
    logic [CW-1:0]          pos_c;
    logic [CW-1:0]          cnt_m1;
    logic [IW-1:0]          rd_idx;
    logic [DATA_WIDTH-1:0]  rd_data;
    logic                   out_free;
    logic                   load_result;
    logic                   div_start;
    logic                   div_done;
    logic [CW-1:0]          div_rem;
    logic [63:0]            value_w;
    logic [15:0]            count_w;

    ile_divider #(
        .CNT_W (CW)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (q_item.amt),
        .divisor   (count_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Operand views
    assign vin_w   = 64'(q_item.value);
    assign wr_val  = vin_w[DATA_WIDTH-1:0];
    assign pos_ext = CMPW'(q_item.pos);
    assign cnt_ext = CMPW'(count_reg);
    assign pos_c   = pos_ext[CW-1:0];
    assign cnt_m1  = count_reg - ONE_C;
    assign rd_idx  = (q_item.cmd == ile_pkg::CMD_POP) ? cnt_m1[IW-1:0] : pos_c[IW-1:0];
    assign rd_data = entries_reg[rd_idx];
    assign out_free = !out_valid_reg || m_tready;

    // Sequence one command at a time
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rot_left_next   = rot_left_reg;
        steps_next      = steps_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        load_result     = 1'b0;
        q_ready         = 1'b0;
        div_start       = 1'b0;
        shift_op        = ile_pkg::SH_NONE;
        wr_idx          = pos_c;
        case (state_reg)
            ile_pkg::ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_ready         = 1'b1;
                    load_result     = 1'b1;
                    out_status_next = ile_pkg::STAT_OK;
                    out_value_next  = '0;
                    case (q_item.cmd)
                        ile_pkg::CMD_PUSH:
                        begin
                            if (count_reg == MAX_C)
                            begin
                                out_status_next = ile_pkg::STAT_FULL;
                            end
                            else
                            begin
                                shift_op   = ile_pkg::SH_WRITE;
                                wr_idx     = count_reg;
                                count_next = count_reg + ONE_C;
                            end
                        end
                        ile_pkg::CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                out_status_next = ile_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                count_next     = cnt_m1;
                                out_value_next = rd_data;
                            end
                        end
                        ile_pkg::CMD_GET:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                out_status_next = ile_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                out_value_next = rd_data;
                            end
                        end
                        ile_pkg::CMD_SET:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                out_status_next = ile_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                shift_op = ile_pkg::SH_WRITE;
                            end
                        end
                        ile_pkg::CMD_INSERT:
                        begin
                            if (pos_ext > cnt_ext)
                            begin
                                out_status_next = ile_pkg::STAT_RANGE;
                            end
                            else if (count_reg == MAX_C)
                            begin
                                out_status_next = ile_pkg::STAT_FULL;
                            end
                            else
                            begin
                                shift_op   = ile_pkg::SH_INSERT;
                                count_next = count_reg + ONE_C;
                            end
                        end
                        ile_pkg::CMD_REMOVE:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                out_status_next = ile_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                shift_op   = ile_pkg::SH_REMOVE;
                                count_next = cnt_m1;
                            end
                        end
                        ile_pkg::CMD_ROTL, ile_pkg::CMD_ROTR:
                        begin
                            // Reduce the amount first; a zero count or amount is a no-op
                            if (count_reg != '0 && q_item.amt != '0)
                            begin
                                load_result   = 1'b0;
                                div_start     = 1'b1;
                                rot_left_next = (q_item.cmd == ile_pkg::CMD_ROTL);
                                state_next    = ile_pkg::ST_DIV;
                            end
                        end
                        ile_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ile_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    if (div_rem == '0)
                    begin
                        load_result     = 1'b1;
                        out_status_next = ile_pkg::STAT_OK;
                        out_value_next  = '0;
                        state_next      = ile_pkg::ST_IDLE;
                    end
                    else
                    begin
                        // Right by k is left by count minus k
                        steps_next = rot_left_reg ? div_rem : count_reg - div_rem;
                        state_next = ile_pkg::ST_ROT;
                    end
                end
            end
            ile_pkg::ST_ROT:
            begin
                shift_op   = ile_pkg::SH_ROTATE;
                steps_next = steps_reg - ONE_C;
                if (steps_reg == ONE_C)
                begin
                    load_result     = 1'b1;
                    out_status_next = ile_pkg::STAT_OK;
                    out_value_next  = '0;
                    state_next      = ile_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ile_pkg::ST_IDLE;
            end
        endcase
        if (load_result)
        begin
            out_valid_next = 1'b1;
            out_count_next = count_next;
        end
    end

    // Shift chain: each entry takes its own value, a neighbor, the first entry (rotate wrap) or the new value
    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            entries_next[i] = entries_reg[i];
            case (shift_op)
                ile_pkg::SH_WRITE:
                begin
                    if (CW'(i) == wr_idx)
                    begin
                        entries_next[i] = wr_val;
                    end
                end
                ile_pkg::SH_INSERT:
                begin
                    if (CW'(i) == wr_idx)
                    begin
                        entries_next[i] = wr_val;
                    end
                    else if (CW'(i) > wr_idx && CW'(i) <= count_reg)
                    begin
                        entries_next[i] = entries_reg[(i > 0) ? i - 1 : 0];
                    end
                end
                ile_pkg::SH_REMOVE:
                begin
                    if (CW'(i) >= wr_idx && CW'(i + 1) < count_reg)
                    begin
                        entries_next[i] = entries_reg[(i < MAX_ENTRIES - 1) ? i + 1 : i];
                    end
                end
                ile_pkg::SH_ROTATE:
                begin
                    if (CW'(i + 1) < count_reg)
                    begin
                        entries_next[i] = entries_reg[(i < MAX_ENTRIES - 1) ? i + 1 : i];
                    end
                    else if (CW'(i + 1) == count_reg)
                    begin
                        entries_next[i] = entries_reg[0];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ile_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            steps_reg     <= '0;
            rot_left_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            steps_reg     <= steps_next;
            rot_left_reg  <= rot_left_next;
        end
    end

    // Payload: list entries and result fields
    always_ff @(posedge clk)
    begin
        entries_reg    <= entries_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
    end

    // Pack the result word
    assign value_w  = 64'(out_value_reg);
    assign count_w  = 16'(out_count_reg);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, count_w[ile_pkg::COUNT_W-1:0],
                       value_w[ile_pkg::VALUE_W-1:0], out_status_reg};

endmodule

// ----- design/indexed_list_engine_core.sv -----
// A simple command passes through the front holding register, the command queue
// and the result register. Throughput: one simple command per cycle while the output
// is not stalled; a rotation holds the back end for an amount-modulo-count division
// and then single-place shift steps (at most MAX_ENTRIES - 1), all on the one shift chain.
// Reset (rst_n, asynchronous, active low) empties the list and the queue;
// entry contents are not cleared and are read only after being written.
module indexed_list_engine_core
#(
    parameter int MAX_ENTRIES = ile_pkg::MAX_ENTRIES_DEF,
    parameter int DATA_WIDTH  = ile_pkg::DATA_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // command[3:0], position[8:4], value_in[40:9], rotate_amount[56:41], zero[63:57]
    input  logic [ile_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[1:0], value_out[33:2], entry_count[38:34], zero[39]
    output logic [ile_pkg::M_TDATA_W-1:0]   m_tdata
);

    logic                 push_valid;
    logic                 push_ready;
    ile_pkg::ile_item_t   push_item;
    logic                 q_valid;
    logic                 q_ready;
    ile_pkg::ile_item_t   q_item;

    ile_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    ile_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    ile_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ile_pkg::*;

    localparam int MAX_ENTRIES  = MAX_ENTRIES_DEF;
    localparam int DATA_WIDTH   = DATA_WIDTH_DEF;
    localparam int RANDOM_ITEMS = 515;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_START   = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 40;
    localparam int UNUSED_SPAN  = 6;

    // One list command as offered on the input stream
    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] value;
        logic [AMT_W-1:0]   amt;
        bit                 drain_first;
    } list_cmd_t;

    // One expected result word
    typedef struct {
        ile_status_t          status;
        logic [VALUE_W-1:0]   value;
        logic [COUNT_W-1:0]   count;
    } list_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // command[3:0], position[8:4], value_in[40:9], rotate_amount[56:41], zero[63:57]
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // status[1:0], value_out[33:2], entry_count[38:34], zero[39]
    logic [M_TDATA_W-1:0] m_tdata;

    list_cmd_t    pending_cmds[$];
    list_result_t expected_results[$];

    // Shadow copy of the list contents
    logic [DATA_WIDTH-1:0] list_mem [MAX_ENTRIES];
    int unsigned           list_count = 0;

    list_cmd_t   bus_cmd;
    int unsigned src_gap = 0;
    int unsigned sink_stall = 0;
    int unsigned words_sent = 0;
    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;
    logic        long_hold = 1'b0;

    indexed_list_engine_core #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .DATA_WIDTH  (DATA_WIDTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Run one command on the shadow list and queue the result it gives
    function automatic void apply_list_command(list_cmd_t c);
        list_result_t          r;
        logic [DATA_WIDTH-1:0] rotated [MAX_ENTRIES];
        int unsigned           i;
        int unsigned           k;
        r.status = STAT_OK;
        r.value  = '0;
        case (c.cmd)
            CMD_PUSH:
                if (list_count >= MAX_ENTRIES)
                    r.status = STAT_FULL;
                else
                begin
                    list_mem[list_count] = c.value[DATA_WIDTH-1:0];
                    list_count++;
                end
            CMD_POP:
                if (list_count == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    list_count--;
                    r.value = VALUE_W'(list_mem[list_count]);
                end
            CMD_GET:
                if (c.pos >= list_count)
                    r.status = STAT_RANGE;
                else
                    r.value = VALUE_W'(list_mem[c.pos]);
            CMD_SET:
                if (c.pos >= list_count)
                    r.status = STAT_RANGE;
                else
                    list_mem[c.pos] = c.value[DATA_WIDTH-1:0];
            CMD_INSERT:
                if (c.pos > list_count)
                    r.status = STAT_RANGE;
                else if (list_count >= MAX_ENTRIES)
                    r.status = STAT_FULL;
                else
                begin
                    for (i = list_count; i > c.pos; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[c.pos] = c.value[DATA_WIDTH-1:0];
                    list_count++;
                end
            CMD_REMOVE:
                if (c.pos >= list_count)
                    r.status = STAT_RANGE;
                else
                begin
                    for (i = c.pos; i + 1 < list_count; i++)
                        list_mem[i] = list_mem[i+1];
                    list_count--;
                end
            CMD_ROTL, CMD_ROTR:
                if (list_count != 0 && c.amt != 0)
                begin
                    k = c.amt % list_count;
                    if (k != 0)
                    begin
                        // a right rotation is a left rotation by the complement
                        if (c.cmd == CMD_ROTR)
                            k = list_count - k;
                        for (i = 0; i < list_count; i++)
                            rotated[i] = list_mem[(i + k) % list_count];
                        for (i = 0; i < list_count; i++)
                            list_mem[i] = rotated[i];
                    end
                end
            CMD_CLEAR:
                list_count = 0;
            default:
                ;
        endcase
        r.count = list_count[COUNT_W-1:0];
        expected_results.push_back(r);
    endfunction

    function automatic void add_cmd(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                    logic [VALUE_W-1:0] value, logic [AMT_W-1:0] amt,
                                    bit drain_first);
        list_cmd_t c;
        c.cmd         = cmd;
        c.pos         = pos;
        c.value       = value;
        c.amt         = amt;
        c.drain_first = drain_first;
        pending_cmds.push_back(c);
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned pick_idle();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Source: present one word at a time, hold it until taken
    always @(posedge clk or negedge rst_n)
    begin : src_drive
        logic stuck;
        logic next_valid;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            src_gap  = 0;
        end
        else
        begin
            stuck = s_tvalid && !s_tready;
            if (s_tvalid && s_tready)
            begin
                apply_list_command(bus_cmd);
                words_sent++;
                // every third run of 64 words goes without gaps
                src_gap = ((words_sent / 64) % 3 == 1) ? 0 : pick_idle();
            end
            if (!stuck)
            begin
                next_valid = 1'b0;
                if (src_gap != 0)
                    src_gap--;
                else if (pending_cmds.size() != 0 &&
                         !(pending_cmds[0].drain_first && expected_results.size() != 0))
                begin
                    bus_cmd = pending_cmds.pop_front();
                    s_tdata <= {7'b0, bus_cmd.amt, bus_cmd.value, bus_cmd.pos, bus_cmd.cmd};
                    next_valid = 1'b1;
                end
                s_tvalid <= next_valid;
            end
        end
    end

    // Sink: random stalls, plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            sink_stall = 0;
        end
        else if (sink_stall != 0)
        begin
            sink_stall--;
            m_tready <= 1'b0;
        end
        else if (long_hold)
            m_tready <= 1'b0;
        else
        begin
            m_tready <= 1'b1;
            if ((cycle_count / 500) % 3 != 2)
                sink_stall = pick_idle();
        end
    end

    // Hold the output off long enough for the block to back up
    initial
    begin
        wait (words_sent >= HOLD_START);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    // Check each result word against the oldest expectation
    always @(posedge clk)
    begin : result_check
        list_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result word %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[1:0] !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, m_tdata[1:0]);
                    fail_count++;
                end
                if (m_tdata[33:2] !== want.value)
                begin
                    $error("value_out: expected %h, actual %h", want.value, m_tdata[33:2]);
                    fail_count++;
                end
                if (m_tdata[38:34] !== want.count)
                begin
                    $error("entry_count: expected %0d, actual %0d", want.count,
                           m_tdata[38:34]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned      n;
        int unsigned      roll;
        bit               fill_phase;
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        logic [AMT_W-1:0] amt;

        // Errors and rotation on an empty list, then a first insert and set
        add_cmd(CMD_POP, 0, 0, 0, 1'b0);
        add_cmd(CMD_GET, 0, 0, 0, 1'b0);
        add_cmd(CMD_REMOVE, 31, 0, 0, 1'b0);
        add_cmd(CMD_INSERT, 1, 0, 0, 1'b0);
        add_cmd(CMD_ROTR, 0, 0, 16'hFFFF, 1'b0);
        add_cmd(CMD_INSERT, 0, 32'hFFFF_FFFF, 0, 1'b0);
        add_cmd(CMD_SET, 0, 32'h0, 0, 1'b0);
        // Fill to capacity, then overflow
        for (n = 0; n < MAX_ENTRIES - 1; n++)
            add_cmd(CMD_PUSH, 0, (n % 2) ? 32'h5A5A_A5A5 ^ n : 32'hA5A5_5A5A ^ n, 0, 1'b0);
        add_cmd(CMD_PUSH, 0, 32'h1234_5678, 0, 1'b0);
        add_cmd(CMD_INSERT, POS_W'(MAX_ENTRIES), 32'h1, 0, 1'b0);
        add_cmd(CMD_INSERT, POS_W'(MAX_ENTRIES + 1), 32'h1, 0, 1'b0);
        add_cmd(CMD_GET, POS_W'(MAX_ENTRIES - 1), 0, 0, 1'b0);
        add_cmd(CMD_SET, POS_W'(MAX_ENTRIES), 32'h2, 0, 1'b0);
        // Amount that reduces to zero, largest amount, one place right, zero amount
        add_cmd(CMD_ROTL, 0, 0, AMT_W'(MAX_ENTRIES), 1'b0);
        add_cmd(CMD_ROTL, 0, 0, 16'hFFFF, 1'b0);
        add_cmd(CMD_ROTR, 0, 0, 1, 1'b0);
        add_cmd(CMD_ROTL, 0, 0, 0, 1'b0);
        add_cmd(CMD_REMOVE, 0, 0, 0, 1'b0);
        add_cmd(CMD_INSERT, POS_W'(MAX_ENTRIES - 1), 32'hDEAD_BEEF, 0, 1'b0);
        add_cmd(CMD_GET, 0, 0, 0, 1'b0);
        add_cmd(CMD_POP, 0, 0, 0, 1'b0);
        add_cmd(CMD_W'(CMD_NOP + UNUSED_SPAN), 31, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        add_cmd(CMD_CLEAR, 0, 0, 0, 1'b0);

        // Random mix, alternating between filling and draining runs
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            fill_phase = ((n / 40) % 2 == 0);
            roll = $urandom_range(0, 99);
            if (roll < 2)
                cmd = CMD_W'(CMD_NOP + $urandom_range(0, UNUSED_SPAN));
            else if (roll < 4)
                cmd = CMD_CLEAR;
            else if (roll < (fill_phase ? 34 : 14))
                cmd = CMD_PUSH;
            else if (roll < (fill_phase ? 42 : 36))
                cmd = CMD_POP;
            else
                cmd = CMD_W'(CMD_GET + $urandom_range(0, CMD_ROTR - CMD_GET));
            roll = $urandom_range(0, 99);
            if (roll < 50)
                pos = POS_W'($urandom_range(0, 8));
            else if (roll < 90)
                pos = POS_W'($urandom_range(0, MAX_ENTRIES));
            else
                pos = POS_W'($urandom_range(0, 31));
            amt = ($urandom_range(0, 99) < 70) ? AMT_W'($urandom_range(0, 40))
                                               : AMT_W'($urandom);
            add_cmd(cmd, pos, $urandom, amt, (n == 0 || n == 300 || n == 450));
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for all words to go out and all results to come back
        while (pending_cmds.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
